/* sv/imu_serial_frame_parser_core_macros.svh */
// Assertion macros for the IMU serial frame parser.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define IMUSFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define IMUSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/imusfp_pkg.sv */
// Shared constants for the IMU serial frame parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imusfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned AgeW     = 16;
  localparam int unsigned ScaleW   = 12;
  localparam int unsigned RateW    = 28;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IdxW     = 4;

  // frame layout: header, type, x, y, z (little endian), two spare bytes, checksum
  localparam logic [IdxW-1:0] LastDataIdx  = 4'd9;
  localparam logic [IdxW-1:0] ChecksumIdx  = 4'd10;
  localparam logic [IdxW-1:0] LastStoreIdx = 4'd7;

  localparam logic [ByteW-1:0] TypeAcc   = 8'h51;
  localparam logic [ByteW-1:0] TypeGyro  = 8'h52;
  localparam logic [ByteW-1:0] TypeEuler = 8'h53;

  localparam logic [1:0] EvFrameOk   = 2'd0;
  localparam logic [1:0] EvUnknown   = 2'd1;
  localparam logic [1:0] EvChecksum  = 2'd2;
  localparam logic [1:0] EvTick      = 2'd3;

  localparam logic [1:0] KindAcc   = 2'd0;
  localparam logic [1:0] KindGyro  = 2'd1;
  localparam logic [1:0] KindEuler = 2'd2;

  localparam logic [CfgIdxW-1:0] RegHeader  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale   = 2'd2;

  localparam logic [ByteW-1:0]  HeaderReset  = 8'd85;
  localparam logic [AgeW-1:0]   TimeoutReset = 16'd100;
  localparam logic [ScaleW-1:0] ScaleReset   = 12'd2000;

endpackage

`default_nettype wire

/* sv/imu_serial_frame_parser_core.sv */
// Top level of the IMU serial frame parser: frame hunting, checksum, ages.
// Depends on imusfp_pkg and imu_serial_frame_parser_core_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  cfg      | cfg_we_i               | cfg_idx_i, cfg_data_i
//  in       | in_valid_i/in_ready_o  | action_i, rx_byte_i
//  out      | out_valid_o/out_ready_i| event_res_o .. euler_stale_o
//
// One item per cycle while in_ready_o is high; any result is in the output
// register in the cycle after its transfer. An item is taken whenever the
// output register is empty or is being emptied in the same cycle. The critical
// path is the 16x12 gyro scale multiply into the output register. Reset clears
// frame state, ages and the valid flag; frame bytes and results keep no reset.
`timescale 1ns / 1ps
`default_nettype none

`include "imu_serial_frame_parser_core_macros.svh"

module imu_serial_frame_parser_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [imusfp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [imusfp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 action_i,
  input  wire logic [imusfp_pkg::ByteW-1:0]         rx_byte_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [1:0]                                event_res_o,
  output logic [1:0]                                frame_kind_o,
  output logic signed [imusfp_pkg::ValueW-1:0]      value_x_o,
  output logic signed [imusfp_pkg::ValueW-1:0]      value_y_o,
  output logic signed [imusfp_pkg::ValueW-1:0]      value_z_o,
  output logic signed [imusfp_pkg::RateW-1:0]       gyro_rate_q15_o,
  output logic                                      acc_stale_o,
  output logic                                      gyro_stale_o,
  output logic                                      euler_stale_o
);

  localparam int unsigned ByteW  = imusfp_pkg::ByteW;
  localparam int unsigned ValueW = imusfp_pkg::ValueW;
  localparam int unsigned AgeW   = imusfp_pkg::AgeW;
  localparam int unsigned ScaleW = imusfp_pkg::ScaleW;
  localparam int unsigned RateW  = imusfp_pkg::RateW;
  localparam int unsigned IdxW   = imusfp_pkg::IdxW;
  localparam int unsigned ProdW  = RateW + 1;

  // configuration
  logic [ByteW-1:0]  header_q;
  logic [AgeW-1:0]   timeout_q;
  logic [ScaleW-1:0] scale_q;

  // frame state
  logic              in_frame_q, in_frame_d;
  logic [IdxW-1:0]   byte_index_q, byte_index_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  frame_q [1:7];
  logic              store_en;

  logic [AgeW-1:0]   acc_age_q, acc_age_d;
  logic [AgeW-1:0]   gyro_age_q, gyro_age_d;
  logic [AgeW-1:0]   euler_age_q, euler_age_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              res_fire;
  logic [1:0]        event_q, event_d;
  logic [1:0]        kind_q, kind_d;
  logic [ValueW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [RateW-1:0]  rate_q, rate_d;
  logic              acc_stale_q, gyro_stale_q, euler_stale_q;

  logic              accept;
  logic [ValueW-1:0] fx, fy, fz;
  logic [ByteW-1:0]  ftype;
  logic signed [ProdW-1:0] gyro_prod;
  logic signed [ProdW-1:0] gyro_neg;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ftype = frame_q[1];
  assign fx    = {frame_q[3], frame_q[2]};
  assign fy    = {frame_q[5], frame_q[4]};
  assign fz    = {frame_q[7], frame_q[6]};

  assign gyro_prod = $signed(fz) * $signed({1'b0, scale_q});
  assign gyro_neg  = -gyro_prod;

  always_comb begin
    in_frame_d   = in_frame_q;
    byte_index_d = byte_index_q;
    sum_d        = sum_q;
    acc_age_d    = acc_age_q;
    gyro_age_d   = gyro_age_q;
    euler_age_d  = euler_age_q;
    store_en     = 1'b0;
    res_fire     = 1'b0;
    event_d      = imusfp_pkg::EvTick;
    kind_d       = imusfp_pkg::KindAcc;
    x_d          = '0;
    y_d          = '0;
    z_d          = '0;
    rate_d       = '0;
    if (accept) begin
      if (action_i) begin
        acc_age_d   = (acc_age_q == '1) ? acc_age_q : acc_age_q + AgeW'(1);
        gyro_age_d  = (gyro_age_q == '1) ? gyro_age_q : gyro_age_q + AgeW'(1);
        euler_age_d = (euler_age_q == '1) ? euler_age_q : euler_age_q + AgeW'(1);
        res_fire    = 1'b1;
        event_d     = imusfp_pkg::EvTick;
      end else if (!in_frame_q) begin
        if (rx_byte_i == header_q) begin
          in_frame_d   = 1'b1;
          sum_d        = rx_byte_i;
          byte_index_d = IdxW'(1);
        end
      end else if (byte_index_q <= imusfp_pkg::LastDataIdx) begin
        store_en     = (byte_index_q <= imusfp_pkg::LastStoreIdx);
        sum_d        = sum_q + rx_byte_i;
        byte_index_d = byte_index_q + IdxW'(1);
      end else begin
        in_frame_d   = 1'b0;
        byte_index_d = '0;
        sum_d        = '0;
        res_fire     = 1'b1;
        if (rx_byte_i != sum_q) begin
          event_d = imusfp_pkg::EvChecksum;
        end else if (ftype inside {imusfp_pkg::TypeAcc, imusfp_pkg::TypeGyro,
                                   imusfp_pkg::TypeEuler}) begin
          event_d = imusfp_pkg::EvFrameOk;
          x_d     = fx;
          y_d     = fy;
          z_d     = fz;
          case (ftype)
            imusfp_pkg::TypeAcc: begin
              kind_d    = imusfp_pkg::KindAcc;
              acc_age_d = '0;
            end
            imusfp_pkg::TypeGyro: begin
              kind_d     = imusfp_pkg::KindGyro;
              gyro_age_d = '0;
              rate_d     = gyro_neg[RateW-1:0];
            end
            default: begin
              kind_d      = imusfp_pkg::KindEuler;
              euler_age_d = '0;
            end
          endcase
        end else begin
          event_d = imusfp_pkg::EvUnknown;
        end
      end
    end
  end

  always_comb begin
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= imusfp_pkg::HeaderReset;
      timeout_q    <= imusfp_pkg::TimeoutReset;
      scale_q      <= imusfp_pkg::ScaleReset;
      in_frame_q   <= 1'b0;
      byte_index_q <= '0;
      sum_q        <= '0;
      acc_age_q    <= '0;
      gyro_age_q   <= '0;
      euler_age_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          imusfp_pkg::RegHeader:  header_q  <= cfg_data_i[ByteW-1:0];
          imusfp_pkg::RegTimeout: timeout_q <= cfg_data_i[AgeW-1:0];
          imusfp_pkg::RegScale:   scale_q   <= cfg_data_i[ScaleW-1:0];
          default: ;
        endcase
      end
      in_frame_q   <= in_frame_d;
      byte_index_q <= byte_index_d;
      sum_q        <= sum_d;
      acc_age_q    <= acc_age_d;
      gyro_age_q   <= gyro_age_d;
      euler_age_q  <= euler_age_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q[byte_index_q[2:0]] <= rx_byte_i;
    end
    if (res_fire) begin
      event_q       <= event_d;
      kind_q        <= kind_d;
      x_q           <= x_d;
      y_q           <= y_d;
      z_q           <= z_d;
      rate_q        <= rate_d;
      acc_stale_q   <= (acc_age_d >= timeout_q);
      gyro_stale_q  <= (gyro_age_d >= timeout_q);
      euler_stale_q <= (euler_age_d >= timeout_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign frame_kind_o    = kind_q;
  assign value_x_o       = $signed(x_q);
  assign value_y_o       = $signed(y_q);
  assign value_z_o       = $signed(z_q);
  assign gyro_rate_q15_o = $signed(rate_q);
  assign acc_stale_o     = acc_stale_q;
  assign gyro_stale_o    = gyro_stale_q;
  assign euler_stale_o   = euler_stale_q;

  `IMUSFP_ASSERT_SAME(a_hunt_idx_zero, !in_frame_q, byte_index_q == '0,
    "byte index not zero while hunting")
  `IMUSFP_ASSERT_SAME(a_frame_idx_range, in_frame_q,
    (byte_index_q != '0) && (byte_index_q <= imusfp_pkg::ChecksumIdx),
    "byte index out of range inside a frame")
  `IMUSFP_ASSERT_NEXT(a_tick_reports, accept && action_i,
    out_valid_q && (event_q == imusfp_pkg::EvTick),
    "tick transfer gave no tick report")
  `IMUSFP_ASSERT_SAME(a_non_ok_zero,
    out_valid_q && (event_q != imusfp_pkg::EvFrameOk),
    (x_q == '0) && (y_q == '0) && (z_q == '0) && (rate_q == '0) &&
    (kind_q == imusfp_pkg::KindAcc),
    "payload not cleared on a non-frame result")

endmodule

`default_nettype wire
